// ----- rtl/ppp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared types and constants of the strict-priority packet packer.
// ----------------------------------------------------------------------------
package ppp_pkg;

    localparam int QUEUE_BYTES_DEF   = 1024;
    localparam int QUEUE_PACKETS_DEF = 64;
    localparam int NUM_CLASSES       = 3;

    localparam logic [7:0] OPEN_BRACKET   = 8'h3C;
    localparam logic [7:0] CLOSE_BRACKET  = 8'h3E;
    localparam logic [7:0] FRAME_BYTES    = 8'd2;
    localparam logic [7:0] MAX_PACKET_LEN = 8'd255;
    localparam logic [7:0] LIMIT_RESET    = 8'd200;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_PULL    = 1'b1;

    localparam logic [1:0] CLASS_IMPORTANT = 2'd0;
    localparam logic [1:0] CLASS_EXPRESS   = 2'd1;
    localparam logic [1:0] CLASS_NORMAL    = 2'd2;

    // Register index (bit 2 of the byte address)
    localparam logic REG_MESSAGE_LIMIT = 1'b0;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_OPEN,
        PH_PAYLOAD,
        PH_CLOSE
    } t_phase;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic       op;
        logic [1:0] priority_class;
        logic [7:0] data_byte;
        logic       packet_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       package_last;
        logic       package_empty;
        logic       enqueue_dropped;
        logic       oversize_dropped;
    } t_out_item;

endpackage

// ----- rtl/priority_packet_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_packet_packer
// Three byte-packet queues in one payload memory and one length memory;
// pulls stream framed packages in strict priority order.
// ----------------------------------------------------------------------------
//  Channel   Handshake                   Payload
//  input     i_in_valid / o_in_ready     i_in_item  (t_in_item)
//  output    o_out_valid / i_out_ready   o_out_item (t_out_item)
//  config    psel/penable/pwrite/pready  paddr, pwdata, prdata
//
//  Each item is accepted in idle, where the payload and length memory reads
//  are issued; the execute state uses the read data and writes back.
//  Items with a result wait while the result register is full and not taken.
//  Reset (synchronous, active low) empties all queues; memories are not
//  cleared, only written entries are ever read.
// ----------------------------------------------------------------------------
module priority_packet_packer #(
    parameter int QUEUE_BYTES   = ppp_pkg::QUEUE_BYTES_DEF,
    parameter int QUEUE_PACKETS = ppp_pkg::QUEUE_PACKETS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ppp_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ppp_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int NC  = ppp_pkg::NUM_CLASSES;
    localparam int PW  = $clog2(QUEUE_BYTES);
    localparam int UW  = $clog2(QUEUE_BYTES + 1);
    localparam int KW  = $clog2(QUEUE_PACKETS);
    localparam int QW  = $clog2(QUEUE_PACKETS + 1);
    localparam int TW  = QW + 1;
    localparam int PAW = $clog2(NC * QUEUE_BYTES);
    localparam int LAW = $clog2(NC * QUEUE_PACKETS);

    // Control and per-class state
    ppp_pkg::t_state    r_state, n_state;
    ppp_pkg::t_phase    r_phase, n_phase;
    ppp_pkg::t_in_item  r_item;
    ppp_pkg::t_out_item r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic [7:0]         r_limit;
    logic [7:0]         r_fill, n_fill;
    logic [7:0]         r_offset, n_offset;
    logic [1:0]         r_emit_class, n_emit_class;
    logic [PW-1:0]      r_rptr [NC], n_rptr [NC];
    logic [PW-1:0]      r_wptr [NC], n_wptr [NC];
    logic [UW-1:0]      r_used [NC], n_used [NC];
    logic [KW-1:0]      r_head [NC], n_head [NC];
    logic [QW-1:0]      r_queued [NC], n_queued [NC];
    logic [7:0]         r_partial [NC], n_partial [NC];

    // Memories
    logic [7:0]     r_pay_mem [NC*QUEUE_BYTES];
    logic [7:0]     r_len_mem [NC*QUEUE_PACKETS];
    logic [7:0]     r_pay_rd, r_len_rd;
    logic [PAW-1:0] w_pay_raddr, w_pay_waddr;
    logic [LAW-1:0] w_len_raddr, w_len_waddr;
    logic           w_pay_we, w_len_we;

    logic           w_accept, w_has_res, w_done, w_take;
    logic           w_any0, w_anyc;
    logic [1:0]     w_fn0, w_fnc;
    logic [KW-1:0]  w_head_c_inc, w_close_idx;
    logic [1:0]     w_len_class;
    logic [KW-1:0]  w_len_idx;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_take   = r_out_valid && i_out_ready;
    assign w_done   = !w_has_res || !r_out_valid || i_out_ready;

    // State machine: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ppp_pkg::ST_IDLE: if (w_accept) n_state = ppp_pkg::ST_EXEC;
            ppp_pkg::ST_EXEC: if (w_done) n_state = ppp_pkg::ST_IDLE;
            default:          n_state = ppp_pkg::ST_IDLE;
        endcase
    end

    // State machine: outputs
    always_comb begin
        case (r_state)
            ppp_pkg::ST_IDLE: o_in_ready = 1'b1;
            default:          o_in_ready = 1'b0;
        endcase
    end

    // First nonempty class from class 0, and from the emit class after its pop
    always_comb begin
        w_any0 = 1'b0;
        w_fn0  = ppp_pkg::CLASS_IMPORTANT;
        w_anyc = 1'b0;
        w_fnc  = ppp_pkg::CLASS_IMPORTANT;
        for (int k = NC - 1; k >= 0; k--) begin
            if (r_queued[k] != '0) begin
                w_any0 = 1'b1;
                w_fn0  = 2'(k);
            end
            if (2'(k) >= r_emit_class) begin
                if ((2'(k) == r_emit_class) ? (r_queued[k] > QW'(1))
                                            : (r_queued[k] != '0)) begin
                    w_anyc = 1'b1;
                    w_fnc  = 2'(k);
                end
            end
        end
    end

    // Head slot after popping the emit class
    always_comb begin
        w_head_c_inc = (r_head[r_emit_class] == KW'(QUEUE_PACKETS - 1))
                       ? '0 : r_head[r_emit_class] + KW'(1);
        w_close_idx  = (w_fnc == r_emit_class) ? w_head_c_inc : r_head[w_fnc];
    end

    // Read addresses follow the phase; held stable until the item executes
    always_comb begin
        case (r_phase)
            ppp_pkg::PH_IDLE: begin
                w_len_class = w_fn0;
                w_len_idx   = r_head[w_fn0];
            end
            ppp_pkg::PH_CLOSE: begin
                w_len_class = w_fnc;
                w_len_idx   = w_close_idx;
            end
            default: begin
                w_len_class = r_emit_class;
                w_len_idx   = r_head[r_emit_class];
            end
        endcase
        w_len_raddr = LAW'(w_len_class) * LAW'(QUEUE_PACKETS) + LAW'(w_len_idx);
        w_pay_raddr = PAW'(r_emit_class) * PAW'(QUEUE_BYTES)
                      + PAW'(r_rptr[r_emit_class]);
    end

    // Execute one item
    always_comb begin
        logic [1:0]    c;
        logic [9:0]    need;
        logic [PW:0]   psum;
        logic [TW-1:0] tail;
        logic [7:0]    fill1;
        logic [7:0]    off1;

        n_phase      = r_phase;
        n_fill       = r_fill;
        n_offset     = r_offset;
        n_emit_class = r_emit_class;
        n_rptr       = r_rptr;
        n_wptr       = r_wptr;
        n_used       = r_used;
        n_head       = r_head;
        n_queued     = r_queued;
        n_partial    = r_partial;
        n_out        = '0;
        w_has_res    = 1'b0;
        w_pay_we     = 1'b0;
        w_len_we     = 1'b0;
        c            = r_item.priority_class;
        need         = '0;
        psum         = '0;
        fill1        = r_fill + 8'd1;
        off1         = r_offset + 8'd1;
        tail         = '0;
        w_pay_waddr  = PAW'(c) * PAW'(QUEUE_BYTES) + PAW'(r_wptr[c]);
        w_len_waddr  = '0;

        if (r_item.op == ppp_pkg::OP_ENQUEUE) begin
            if (c == 2'd3 || r_used[c] >= UW'(QUEUE_BYTES)
                    || r_queued[c] >= QW'(QUEUE_PACKETS)
                    || r_partial[c] == ppp_pkg::MAX_PACKET_LEN) begin
                w_has_res             = 1'b1;
                n_out.enqueue_dropped = 1'b1;
            end else begin
                w_pay_we     = 1'b1;
                n_wptr[c]    = (r_wptr[c] == PW'(QUEUE_BYTES - 1))
                               ? '0 : r_wptr[c] + PW'(1);
                n_used[c]    = r_used[c] + UW'(1);
                n_partial[c] = r_partial[c] + 8'd1;
                if (r_item.packet_end) begin
                    tail = TW'(r_head[c]) + TW'(r_queued[c]);
                    if (tail >= TW'(QUEUE_PACKETS)) tail = tail - TW'(QUEUE_PACKETS);
                    w_len_we     = 1'b1;
                    w_len_waddr  = LAW'(c) * LAW'(QUEUE_PACKETS) + LAW'(tail[KW-1:0]);
                    n_queued[c]  = r_queued[c] + QW'(1);
                    n_partial[c] = 8'd0;
                end
            end
        end else begin
            w_has_res = 1'b1;
            case (r_phase)
                ppp_pkg::PH_IDLE: begin
                    if (!w_any0) begin
                        n_out.package_empty = 1'b1;
                    end else if (10'(r_len_rd) + 10'(ppp_pkg::FRAME_BYTES)
                                 > 10'(r_limit)) begin
                        // Drop an oversize head packet
                        psum = (PW+1)'(r_rptr[w_fn0]) + (PW+1)'(r_len_rd);
                        if (psum >= (PW+1)'(QUEUE_BYTES))
                            psum = psum - (PW+1)'(QUEUE_BYTES);
                        n_rptr[w_fn0]          = psum[PW-1:0];
                        n_used[w_fn0]          = r_used[w_fn0] - UW'(r_len_rd);
                        n_head[w_fn0]          = (r_head[w_fn0] == KW'(QUEUE_PACKETS - 1))
                                                 ? '0 : r_head[w_fn0] + KW'(1);
                        n_queued[w_fn0]        = r_queued[w_fn0] - QW'(1);
                        n_out.package_empty    = 1'b1;
                        n_out.oversize_dropped = 1'b1;
                    end else begin
                        n_emit_class   = w_fn0;
                        n_out.out_byte = ppp_pkg::OPEN_BRACKET;
                        n_fill         = fill1;
                        n_offset       = 8'd0;
                        n_phase        = ppp_pkg::PH_PAYLOAD;
                    end
                end
                ppp_pkg::PH_OPEN: begin
                    n_out.out_byte = ppp_pkg::OPEN_BRACKET;
                    n_fill         = fill1;
                    n_offset       = 8'd0;
                    n_phase        = ppp_pkg::PH_PAYLOAD;
                end
                ppp_pkg::PH_PAYLOAD: begin
                    n_out.out_byte         = r_pay_rd;
                    n_rptr[r_emit_class]   = (r_rptr[r_emit_class] == PW'(QUEUE_BYTES - 1))
                                             ? '0 : r_rptr[r_emit_class] + PW'(1);
                    n_used[r_emit_class]   = r_used[r_emit_class] - UW'(1);
                    n_offset               = off1;
                    n_fill                 = fill1;
                    if (off1 >= r_len_rd) n_phase = ppp_pkg::PH_CLOSE;
                end
                default: begin
                    n_out.out_byte         = ppp_pkg::CLOSE_BRACKET;
                    n_head[r_emit_class]   = w_head_c_inc;
                    n_queued[r_emit_class] = r_queued[r_emit_class] - QW'(1);
                    need = 10'(fill1) + 10'(r_len_rd) + 10'(ppp_pkg::FRAME_BYTES);
                    if (w_anyc && need <= 10'(r_limit)) begin
                        n_fill       = fill1;
                        n_emit_class = w_fnc;
                        n_phase      = ppp_pkg::PH_OPEN;
                    end else begin
                        n_out.package_last = 1'b1;
                        n_phase            = ppp_pkg::PH_IDLE;
                        n_fill             = 8'd0;
                        n_offset           = 8'd0;
                    end
                end
            endcase
        end
    end

    // Result register
    always_comb begin
        n_out_valid = r_out_valid && !w_take;
        if (r_state == ppp_pkg::ST_EXEC && w_done && w_has_res) n_out_valid = 1'b1;
    end

    // Memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (r_state == ppp_pkg::ST_EXEC && w_done && w_pay_we)
            r_pay_mem[w_pay_waddr] <= r_item.data_byte;
        r_pay_rd <= r_pay_mem[w_pay_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ppp_pkg::ST_EXEC && w_done && w_len_we)
            r_len_mem[w_len_waddr] <= r_partial[r_item.priority_class] + 8'd1;
        r_len_rd <= r_len_mem[w_len_raddr];
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) r_item <= i_in_item;
        if (r_state == ppp_pkg::ST_EXEC && w_done && w_has_res) r_out <= n_out;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ppp_pkg::ST_IDLE;
            r_phase      <= ppp_pkg::PH_IDLE;
            r_out_valid  <= 1'b0;
            r_limit      <= ppp_pkg::LIMIT_RESET;
            r_fill       <= '0;
            r_offset     <= '0;
            r_emit_class <= ppp_pkg::CLASS_IMPORTANT;
            for (int k = 0; k < NC; k++) begin
                r_rptr[k]    <= '0;
                r_wptr[k]    <= '0;
                r_used[k]    <= '0;
                r_head[k]    <= '0;
                r_queued[k]  <= '0;
                r_partial[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (psel && penable && pwrite && paddr[2] == ppp_pkg::REG_MESSAGE_LIMIT)
                r_limit <= pwdata[7:0];
            if (r_state == ppp_pkg::ST_EXEC && w_done) begin
                r_phase      <= n_phase;
                r_fill       <= n_fill;
                r_offset     <= n_offset;
                r_emit_class <= n_emit_class;
                r_rptr       <= n_rptr;
                r_wptr       <= n_wptr;
                r_used       <= n_used;
                r_head       <= n_head;
                r_queued     <= n_queued;
                r_partial    <= n_partial;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == ppp_pkg::REG_MESSAGE_LIMIT) ? {24'd0, r_limit} : 32'd0;

    // A package in progress always has its current packet queued
    a_emit_has_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != ppp_pkg::PH_IDLE |-> r_queued[r_emit_class] != '0)
        else $error("emit class queue empty during a package");

    // No package fill outside a package
    a_idle_fill_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == ppp_pkg::PH_IDLE |-> r_fill == 8'd0)
        else $error("package fill nonzero while idle");

    // Byte store occupancy of the emit class never exceeds its size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used[r_emit_class] <= UW'(QUEUE_BYTES))
        else $error("byte store occupancy overflow");

    // A full result register is not overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out))
        else $error("pending result lost");

endmodule
